>>> rtl/core/fcull_pkg.sv
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types and constants for the frustum cull tester.
// ----------------------------------------------------------------------------
package fcull_pkg;

  localparam int NUM_PLANES_DEF  = 6;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int LAST_CORNER     = 7;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_POINT  = 2'd1,
    OP_SPHERE = 2'd2,
    OP_BOX    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CF_A = 2'd0,
    CF_B = 2'd1,
    CF_C = 2'd2,
    CF_D = 2'd3
  } coeff_t;

  // classified item as it travels from front to back
  typedef struct packed {
    op_t                op;
    logic [2:0]         plane;
    logic [1:0]         coeff;
    logic [31:0]        value;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic [31:0]        bias;
    logic [2:0]         last_k;
  } item_t;

endpackage

>>> rtl/core/frustum_cull_tester_top.sv
// ----------------------------------------------------------------------------
// frustum_cull_tester_top
// Frustum culling of points, spheres and boxes against stored planes.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue; a load writes the plane store as it is
// popped and yields no result. A test visits one corner per cycle through a
// three-stage coordinate / multiply / sum pipeline with one dot unit per
// plane: a point or sphere test visits one corner, a box test all eight.
// The back end starts a test only once the previous result has been popped.
// ----------------------------------------------------------------------------
module frustum_cull_tester_top #(
  parameter int NUM_PLANES  = fcull_pkg::NUM_PLANES_DEF,
  parameter int COORD_WIDTH = fcull_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_op,
  input  logic [2:0]         in_plane_index,
  input  logic [1:0]         in_coeff_index,
  input  logic signed [31:0] in_coeff_value,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_extent_x,
  input  logic signed [31:0] in_extent_y,
  input  logic signed [31:0] in_extent_z,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_visible,
  output logic [1:0]         out_test_kind
);
  import fcull_pkg::*;

  item_t f_item, q_item;
  logic  q_empty, q_pop;

  fcull_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .in_op          (in_op),
    .in_plane_index (in_plane_index),
    .in_coeff_index (in_coeff_index),
    .in_coeff_value (in_coeff_value),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_center_z    (in_center_z),
    .in_extent_x    (in_extent_x),
    .in_extent_y    (in_extent_y),
    .in_extent_z    (in_extent_z),
    .item           (f_item)
  );

  fcull_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (f_item),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_item)
  );

  fcull_back #(.NUM_PLANES(NUM_PLANES)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_visible   (out_visible),
    .out_test_kind (out_test_kind)
  );

endmodule

>>> rtl/core/fcull_front.sv
// ----------------------------------------------------------------------------
// fcull_front
// Decodes an incoming item: trims coordinates to the coordinate width, folds
// the sphere radius to a bias and sets the number of corners to visit.
// ----------------------------------------------------------------------------
module fcull_front #(
  parameter int COORD_WIDTH = fcull_pkg::COORD_WIDTH_DEF
) (
  input  logic [1:0]         in_op,
  input  logic [2:0]         in_plane_index,
  input  logic [1:0]         in_coeff_index,
  input  logic signed [31:0] in_coeff_value,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic signed [31:0] in_extent_x,
  input  logic signed [31:0] in_extent_y,
  input  logic signed [31:0] in_extent_z,
  output fcull_pkg::item_t   item
);
  import fcull_pkg::*;

  function automatic logic signed [31:0] trim(input logic [31:0] v);
    logic signed [COORD_WIDTH-1:0] t;
    t = v[COORD_WIDTH-1:0];
    return 32'(t);
  endfunction

  logic signed [31:0] ex_s, ey_s, ez_s;
  op_t                op;

  always_comb begin
    op   = op_t'(in_op);
    ex_s = trim(in_extent_x);
    ey_s = trim(in_extent_y);
    ez_s = trim(in_extent_z);
    item.op     = op;
    item.plane  = in_plane_index;
    item.coeff  = in_coeff_index;
    item.value  = in_coeff_value;
    item.cx     = trim(in_center_x);
    item.cy     = trim(in_center_y);
    item.cz     = trim(in_center_z);
    item.ex     = '0;
    item.ey     = '0;
    item.ez     = '0;
    item.bias   = '0;
    item.last_k = '0;
    unique case (op)
      OP_BOX: begin
        item.ex     = ex_s;
        item.ey     = ey_s;
        item.ez     = ez_s;
        item.last_k = 3'(LAST_CORNER);
      end
      OP_SPHERE: begin
        item.bias = ex_s[31] ? 32'(-ex_s) : 32'(ex_s);
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/fcull_queue.sv
// ----------------------------------------------------------------------------
// fcull_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module fcull_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fcull_pkg::item_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output fcull_pkg::item_t rdata
);
  import fcull_pkg::*;

  item_t      mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/core/fcull_back.sv
// ----------------------------------------------------------------------------
// fcull_back
// Holds the plane store, runs tests one corner per cycle through a
// coordinate / multiply / sum pipeline against all planes, and keeps the
// one-entry result register.
// ----------------------------------------------------------------------------
module fcull_back #(
  parameter int NUM_PLANES = fcull_pkg::NUM_PLANES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  fcull_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic             out_visible,
  output logic [1:0]       out_test_kind
);
  import fcull_pkg::*;

  localparam int PIW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int SW  = 68;

  logic [31:0]        coef_r [NUM_PLANES][4];
  item_t              item_r;
  logic               busy_r, issue_r;
  logic [2:0]         k_r;
  logic signed [32:0] x_r, y_r, z_r;
  logic               v1_r, last1_r, v2_r, last2_r;
  logic signed [64:0] prod_r [NUM_PLANES][3];
  logic [NUM_PLANES-1:0] ok_r, ok_now;
  logic               res_valid_r, res_vis_r;
  logic [1:0]         res_kind_r;

  logic start_load, start_test, plane_ok;

  assign plane_ok   = ({1'b0, q_item.plane} < 4'(NUM_PLANES));
  assign start_load = !busy_r && !q_empty && (q_item.op == OP_LOAD);
  assign start_test = !busy_r && !q_empty && (q_item.op != OP_LOAD) && !res_valid_r;
  assign q_pop      = start_load || start_test;

  assign out_empty     = !res_valid_r;
  assign out_visible   = res_vis_r;
  assign out_test_kind = res_kind_r;

  always_comb begin
    logic signed [SW-1:0] s;
    for (int p = 0; p < NUM_PLANES; p++) begin
      s = SW'(prod_r[p][0]) + SW'(prod_r[p][1]) + SW'(prod_r[p][2])
        + (SW'($signed(coef_r[p][CF_D])) <<< 16)
        + (SW'($signed({1'b0, item_r.bias})) <<< 16);
      ok_now[p] = ok_r[p] | !s[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int j = 0; j < 4; j++) begin
          coef_r[p][j] <= '0;
        end
      end
    end else if (start_load && plane_ok) begin
      coef_r[q_item.plane[PIW-1:0]][q_item.coeff] <= q_item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      issue_r     <= 1'b0;
      k_r         <= '0;
      v1_r        <= 1'b0;
      last1_r     <= 1'b0;
      v2_r        <= 1'b0;
      last2_r     <= 1'b0;
      ok_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      v1_r    <= issue_r;
      last1_r <= issue_r && (k_r == item_r.last_k);
      v2_r    <= v1_r;
      last2_r <= last1_r;
      if (start_test) begin
        busy_r  <= 1'b1;
        issue_r <= 1'b1;
        k_r     <= '0;
        ok_r    <= '0;
      end else if (issue_r) begin
        k_r <= k_r + 3'd1;
        if (k_r == item_r.last_k) begin
          issue_r <= 1'b0;
        end
      end
      if (v2_r) begin
        ok_r <= ok_now;
      end
      if (out_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      if (v2_r && last2_r) begin
        res_valid_r <= 1'b1;
        busy_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_test) begin
      item_r <= q_item;
    end
    x_r <= k_r[0] ? 33'(item_r.cx) + 33'(item_r.ex) : 33'(item_r.cx) - 33'(item_r.ex);
    y_r <= k_r[1] ? 33'(item_r.cy) + 33'(item_r.ey) : 33'(item_r.cy) - 33'(item_r.ey);
    z_r <= k_r[2] ? 33'(item_r.cz) + 33'(item_r.ez) : 33'(item_r.cz) - 33'(item_r.ez);
    for (int p = 0; p < NUM_PLANES; p++) begin
      prod_r[p][0] <= $signed(coef_r[p][CF_A]) * x_r;
      prod_r[p][1] <= $signed(coef_r[p][CF_B]) * y_r;
      prod_r[p][2] <= $signed(coef_r[p][CF_C]) * z_r;
    end
    if (v2_r && last2_r) begin
      res_vis_r  <= &ok_now;
      res_kind_r <= item_r.op;
    end
  end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Frustum cull tester bench: loads planes, runs point/sphere/box tests with
// random idling on both sides and checks each result against a local model.
// ----------------------------------------------------------------------------
module tb;
  import fcull_pkg::*;

  localparam int NPL = 6;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_op = OP_LOAD;
  logic [2:0]  in_plane_index = '0;
  logic [1:0]  in_coeff_index = '0;
  logic signed [31:0] in_coeff_value = '0;
  logic signed [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic signed [31:0] in_extent_x = '0, in_extent_y = '0, in_extent_z = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_visible;
  logic [1:0]  out_test_kind;

  typedef struct {
    logic       visible;
    logic [1:0] kind;
  } verdict_t;

  logic signed [31:0] planes [NPL*4];
  verdict_t verdicts_due[$];
  int errors = 0;
  int idle_cycles = 0;
  int pop_wait = 0;
  logic stim_done = 1'b0;

  frustum_cull_tester_top u_top (.*);

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic dist_neg(input int p, input logic signed [33:0] x,
                                    input logic signed [33:0] y,
                                    input logic signed [33:0] z,
                                    input logic signed [33:0] r);
    logic signed [127:0] s;
    s = 128'(planes[p*4]) * 128'(x) + 128'(planes[p*4+1]) * 128'(y)
      + 128'(planes[p*4+2]) * 128'(z) + (128'(planes[p*4+3]) <<< 16)
      + (128'(r) <<< 16);
    return s[127];
  endfunction

  function automatic logic cull_visible(input op_t op,
      input logic signed [31:0] cx, cy, cz, ex, ey, ez);
    logic signed [33:0] rad, x, y, z;
    logic any;
    rad = ex < 0 ? -34'(ex) : 34'(ex);
    for (int p = 0; p < NPL; p++) begin
      if (op == OP_POINT) begin
        if (dist_neg(p, cx, cy, cz, 0)) return 1'b0;
      end else if (op == OP_SPHERE) begin
        if (dist_neg(p, cx, cy, cz, rad)) return 1'b0;
      end else begin
        any = 1'b0;
        for (int k = 0; k < 8; k++) begin
          x = k[0] ? 34'(cx) + 34'(ex) : 34'(cx) - 34'(ex);
          y = k[1] ? 34'(cy) + 34'(ey) : 34'(cy) - 34'(ey);
          z = k[2] ? 34'(cz) + 34'(ez) : 34'(cz) - 34'(ez);
          if (!dist_neg(p, x, y, z, 0)) any = 1'b1;
        end
        if (!any) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic send(input op_t op, input logic [2:0] pl, input logic [1:0] ci,
      input logic [31:0] cv, input logic [31:0] cx, cy, cz, ex, ey, ez);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_op <= op;
    in_plane_index <= pl;
    in_coeff_index <= ci;
    in_coeff_value <= cv;
    in_center_x <= cx; in_center_y <= cy; in_center_z <= cz;
    in_extent_x <= ex; in_extent_y <= ey; in_extent_z <= ez;
    do @(posedge clk); while (in_full);
    if (op == OP_LOAD) begin
      if (pl < NPL) planes[pl*4+ci] = cv;
    end else begin
      verdicts_due.push_back('{cull_visible(op, cx, cy, cz, ex, ey, ez), op});
    end
  endtask

  task automatic flush();
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3) << 16;
      3: return -($urandom_range(0, 3) << 16);
      4: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_plane(input int p, input logic [31:0] a, b, c, d);
    send(OP_LOAD, 3'(p), CF_A, a, 0, 0, 0, 0, 0, 0);
    send(OP_LOAD, 3'(p), CF_B, b, 0, 0, 0, 0, 0, 0);
    send(OP_LOAD, 3'(p), CF_C, c, 0, 0, 0, 0, 0, 0);
    send(OP_LOAD, 3'(p), CF_D, d, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_directed();
    // zero planes: everything visible
    send(OP_POINT, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0);
    send(OP_SPHERE, 0, 0, 0, 1, 2, 3, 32'h8000_0000, 0, 0);
    send(OP_BOX, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
         32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    load_plane(0, 32'h0001_0000, 0, 0, 0);  // x >= 0
    send(OP_LOAD, 6, CF_D, 32'hffff_ffff, 0, 0, 0, 0, 0, 0);
    send(OP_LOAD, 7, CF_A, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
    send(OP_POINT, 0, 0, 0, -32'sd1, 0, 0, 0, 0, 0);
    send(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_SPHERE, 0, 0, 0, -32'sd5, 0, 0, -32'sd5, 0, 0);
    send(OP_SPHERE, 0, 0, 0, -32'sd5, 0, 0, -32'sd4, 0, 0);
    send(OP_BOX, 0, 0, 0, -32'sd5, 0, 0, -32'sd4, 0, 0);
    send(OP_BOX, 0, 0, 0, -32'sd5, 0, 0, -32'sd6, 0, 0);
    send(OP_BOX, 0, 0, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, 1, 1);
    load_plane(5, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send(OP_POINT, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
    send(OP_BOX, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    flush();
  endtask

  task automatic test_random();
    op_t op;
    int n;
    n = 0;
    while (n < 1530) begin
      if ($urandom_range(0, 9) == 0) begin
        send(OP_LOAD, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), rnd_word(),
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        n++;
      end else if ($urandom_range(0, 19) == 0) begin
        // fresh frustum: small A, B and C coefficients so tests split both ways
        for (int p = 0; p < NPL; p++)
          load_plane(p, $urandom_range(0, 32'h3ffff) - 32'h20000,
                     $urandom_range(0, 32'h3ffff) - 32'h20000,
                     $urandom_range(0, 32'h3ffff) - 32'h20000, rnd_word());
        n += 4 * NPL;
      end else begin
        op = op_t'($urandom_range(1, 3));
        send(op, 3'($urandom), 2'($urandom), $urandom, rnd_word(), rnd_word(),
             rnd_word(), rnd_word(), rnd_word(), rnd_word());
        n++;
      end
    end
    flush();
  endtask

  always @(posedge clk) begin
    int w;
    if (!rst_n || stim_done) begin
      out_pop  <= 1'b0;
      pop_wait <= 0;
    end else if (out_pop && !out_empty) begin
      w = $urandom_range(0, 4);
      pop_wait <= w;
      out_pop  <= (w == 0);
    end else if (!out_pop) begin
      if (pop_wait == 0) out_pop <= 1'b1;
      else pop_wait <= pop_wait - 1;
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_pop && !out_empty) begin
      if (verdicts_due.size() == 0) begin
        report("result with nothing expected");
      end else begin
        v = verdicts_due.pop_front();
        if (out_visible !== v.visible)
          report($sformatf("visible got %b want %b", out_visible, v.visible));
        if (out_test_kind !== v.kind)
          report($sformatf("test_kind got %0d want %0d", out_test_kind, v.kind));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NPL*4; i++) planes[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    stim_done = 1'b1;
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> frustum_cull_tester_top.f
rtl/core/fcull_pkg.sv
rtl/core/fcull_front.sv
rtl/core/fcull_queue.sv
rtl/core/fcull_back.sv
rtl/core/frustum_cull_tester_top.sv
dv/tb.sv
